@@ design/deq_pkg.sv @@
// deq_pkg: shared types and codes for the double-ended queue
// depends on nothing; used by deq_ctrl, deq_dp and double_ended_queue
package deq_pkg;

  localparam int DEPTH_DEF = 1024;

  // actions
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [2:0] ACT_PEEK_BACK  = 3'd5;
  localparam logic [2:0] ACT_CLEAR      = 3'd6;
  localparam logic [2:0] ACT_QUERY      = 3'd7;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } stat_t;

endpackage

@@ design/double_ended_queue.sv @@
// double_ended_queue: top level of the double-ended queue of signed 64-bit values
// depends on deq_pkg, deq_ctrl and deq_dp
//
// Each request names one action (push or pop at either end, peek at either end,
// clear, query) and returns exactly one result with the data read, a status
// (ok, empty, full) and the entry count after the action. An item passes in
// order through capture at the accepting edge, one access of the single-port
// ring store, and the load of the result register from the registered read
// data. The input takes a new request only once the previous one has reached
// the result register. A result waiting in the output register holds off only
// the third step, so the input takes the next request while the previous
// result is still unclaimed. Entries are kept in a DEPTH-entry memory with no
// reset; the pointers and the count clear at reset and the block is usable on
// the next cycle.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [63:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] data,
  output logic [1:0]         status,
  output logic [CW-1:0]      count
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t st;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH),
    .PW    ($clog2(DEPTH)),
    .CW    (CW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .status    (status),
    .count     (count)
  );

endmodule

@@ design/deq_ctrl.sv @@
// deq_ctrl: sequencer for the double-ended queue (capture, execute, respond)
// depends on deq_pkg; drives the command struct of deq_dp
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::stat_t st,
  output deq_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.finish = (state == S_DONE) && !st.out_hold;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_hold) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec) else $error("load not followed by execute");
  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (state == S_DONE && !in_ready)) else $error("execute not followed by done");
  a_finish_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> in_ready) else $error("finish not followed by idle");
`endif

endmodule

@@ design/deq_dp.sv @@
// deq_dp: datapath of the double-ended queue: ring store, pointers, count, result register
// depends on deq_pkg; commanded by deq_ctrl
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  deq_pkg::cmd_t        cmd,
  output deq_pkg::stat_t       st,
  input  logic [2:0]           action,
  input  logic signed [63:0]   value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [63:0]   data,
  output logic [1:0]           status,
  output logic [CW-1:0]        count
);

  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [2:0]         act;
  logic [63:0]        val;
  logic [PW-1:0]      head;
  logic [PW-1:0]      tail;
  logic [CW-1:0]      cnt;
  logic [PW-1:0]      head_next;
  logic [PW-1:0]      tail_next;
  logic [CW-1:0]      cnt_next;
  logic [1:0]         res_status;
  logic [1:0]         res_status_next;
  logic               res_rd;
  logic               res_rd_next;
  logic [63:0]        mem [DEPTH];
  logic [63:0]        rdata;
  logic [PW-1:0]      addr;
  logic               mem_we;
  logic               mem_re;
  logic [PW-1:0]      head_prev;
  logic [PW-1:0]      head_succ;
  logic [PW-1:0]      tail_prev;
  logic [PW-1:0]      tail_succ;
  logic               empty;
  logic               full;
  logic [CW:0]        ptr_sum;
  logic [CW:0]        ptr_wrap;

  assign head_prev = (head == '0) ? LAST : head - 1'b1;
  assign head_succ = (head == LAST) ? '0 : head + 1'b1;
  assign tail_prev = (tail == '0) ? LAST : tail - 1'b1;
  assign tail_succ = (tail == LAST) ? '0 : tail + 1'b1;
  assign empty     = (cnt == '0);
  assign full      = (cnt == FULL_CNT);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    cnt_next        = cnt;
    res_status_next = deq_pkg::ST_OK;
    res_rd_next     = 1'b0;
    addr            = head;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    case (act)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          res_status_next = deq_pkg::ST_FULL;
        end else begin
          head_next = head_prev;
          addr      = head_prev;
          mem_we    = 1'b1;
          cnt_next  = cnt + 1'b1;
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          res_status_next = deq_pkg::ST_FULL;
        end else begin
          tail_next = tail_succ;
          addr      = tail;
          mem_we    = 1'b1;
          cnt_next  = cnt + 1'b1;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          res_status_next = deq_pkg::ST_EMPTY;
        end else begin
          head_next   = head_succ;
          addr        = head;
          mem_re      = 1'b1;
          res_rd_next = 1'b1;
          cnt_next    = cnt - 1'b1;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          res_status_next = deq_pkg::ST_EMPTY;
        end else begin
          tail_next   = tail_prev;
          addr        = tail_prev;
          mem_re      = 1'b1;
          res_rd_next = 1'b1;
          cnt_next    = cnt - 1'b1;
        end
      end
      deq_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          res_status_next = deq_pkg::ST_EMPTY;
        end else begin
          addr        = head;
          mem_re      = 1'b1;
          res_rd_next = 1'b1;
        end
      end
      deq_pkg::ACT_PEEK_BACK: begin
        if (empty) begin
          res_status_next = deq_pkg::ST_EMPTY;
        end else begin
          addr        = tail_prev;
          mem_re      = 1'b1;
          res_rd_next = 1'b1;
        end
      end
      deq_pkg::ACT_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // ring store, one access per item
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[addr] <= val;
    end
    if (cmd.exec && mem_re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      val <= value;
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
      res_rd     <= res_rd_next;
    end
    if (cmd.finish) begin
      data   <= res_rd ? rdata : '0;
      status <= res_status;
      count  <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head <= head_next;
        tail <= tail_next;
        cnt  <= cnt_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.out_hold = out_valid && !out_ready;

  // front slot plus entry count lands on the tail pointer, the slot after the back entry
  assign ptr_sum  = (CW + 1)'(head) + (CW + 1)'(cnt);
  assign ptr_wrap = (ptr_sum >= (CW + 1)'(DEPTH)) ? ptr_sum - (CW + 1)'(DEPTH) : ptr_sum;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT) else $error("entry count above depth");
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    ptr_wrap == (CW + 1)'(tail)) else $error("pointers disagree with count");
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && res_status == deq_pkg::ST_FULL) |-> cnt == FULL_CNT)
    else $error("full status with room left");
  a_empty_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && res_status == deq_pkg::ST_EMPTY) |-> cnt == '0)
    else $error("empty status with entries held");
`endif

endmodule
